// ===== hdl/batched_transpose_address_gen_defines.svh =====
// Assertion macros for the batched transpose address generator.
// Included by btag_index_gen, the RTL file that carries concurrent checks; no dependencies.
`ifndef BATCHED_TRANSPOSE_ADDRESS_GEN_DEFINES_SVH
`define BATCHED_TRANSPOSE_ADDRESS_GEN_DEFINES_SVH
`ifndef SYNTHESIS
`define BTAG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("btag check failed");
`define BTAG_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("btag check failed");
`else
`define BTAG_ASSERT(label, clk, rst_n, prop)
`define BTAG_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== hdl/btag_pkg.sv =====
// Shared types and constants of the batched transpose address generator.
// No dependencies; used by the interfaces and all modules.
package btag_pkg;

    localparam int ELEM_W      = 64;
    localparam int INDEX_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int BATCH_CNT_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BATCH_COUNT = 2'd0,
        REG_ROWS_IN     = 2'd1,
        REG_COLS_IN     = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               last;
    } addr_t;

endpackage

// ===== hdl/btag_if.sv =====
// Handshake channels of the batched transpose address generator.
// Depends on btag_pkg for payload widths.
interface btag_elem_if;
    logic                       valid;
    logic                       ready;
    logic [btag_pkg::ELEM_W-1:0] elem_value;

    modport source (output valid, output elem_value, input ready);
    modport sink   (input valid, input elem_value, output ready);
endinterface

interface btag_result_if;
    logic                        valid;
    logic                        ready;
    logic [btag_pkg::ELEM_W-1:0]  out_value;
    logic [btag_pkg::INDEX_W-1:0] out_index;
    logic                        last_of_tensor;

    modport source (output valid, output out_value, output out_index,
                    output last_of_tensor, input ready);
    modport sink   (input valid, input out_value, input out_index,
                    input last_of_tensor, output ready);
endinterface

interface btag_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [btag_pkg::CFG_IDX_W-1:0]  index;
    logic [btag_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/btag_index_gen.sv =====
// Shape registers and running counters; produces the output index of each beat.
// Depends on btag_pkg and the assertion macro header.
`include "batched_transpose_address_gen_defines.svh"

module btag_index_gen #(
    parameter int DIM_BITS   = 12,
    parameter int BATCH_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  btag_pkg::cfg_wr_t cfg_wr,
    output btag_pkg::addr_t   addr
);

    localparam int OFF_W  = 2 * DIM_BITS;
    localparam int PROD_W = 2 * DIM_BITS + 2;
    localparam int DCW    = (DIM_BITS + 1 > btag_pkg::CFG_DATA_W) ?
                            DIM_BITS + 1 : btag_pkg::CFG_DATA_W;
    localparam int BCW    = (BATCH_BITS + 1 > btag_pkg::BATCH_CNT_W) ?
                            BATCH_BITS + 1 : btag_pkg::BATCH_CNT_W;

    // clamp a count to 1..2^DIM_BITS and return count - 1
    function automatic logic [DIM_BITS-1:0] dim_last(input logic [DCW-1:0] v);
        logic [DCW-1:0] limit;
        limit = DCW'(1) << DIM_BITS;
        if (v == '0)
            return '0;
        else if (v > limit)
            return DIM_BITS'(limit - DCW'(1));
        else
            return DIM_BITS'(v - DCW'(1));
    endfunction

    function automatic logic [BATCH_BITS-1:0] batch_last(input logic [BCW-1:0] v);
        logic [BCW-1:0] limit;
        limit = BCW'(1) << BATCH_BITS;
        if (v == '0)
            return '0;
        else if (v > limit)
            return BATCH_BITS'(limit - BCW'(1));
        else
            return BATCH_BITS'(v - BCW'(1));
    endfunction

    logic [DIM_BITS-1:0]   col_last_reg, col_last_next;
    logic [DIM_BITS-1:0]   row_last_reg, row_last_next;
    logic [BATCH_BITS-1:0] batch_last_reg, batch_last_next;
    logic [31:0]           slab_reg, slab_next;
    logic [PROD_W-1:0]     slab_prod;

    logic [DIM_BITS-1:0]   col_pos_reg, col_pos_next;
    logic [DIM_BITS-1:0]   row_pos_reg, row_pos_next;
    logic [BATCH_BITS-1:0] batch_pos_reg, batch_pos_next;
    logic [OFF_W-1:0]      col_offset_reg, col_offset_next;
    logic [31:0]           batch_base_reg, batch_base_next;

    logic [OFF_W-1:0]      rows_ext;
    logic                  col_end, row_end, batch_end;

    always_comb
    begin
        col_last_next   = col_last_reg;
        row_last_next   = row_last_reg;
        batch_last_next = batch_last_reg;
        if (cfg_wr.valid)
        begin
            unique case (cfg_wr.index)
                btag_pkg::REG_BATCH_COUNT:
                    batch_last_next = batch_last(BCW'(cfg_wr.data[btag_pkg::BATCH_CNT_W-1:0]));
                btag_pkg::REG_ROWS_IN:
                    row_last_next = dim_last(DCW'(cfg_wr.data));
                btag_pkg::REG_COLS_IN:
                    col_last_next = dim_last(DCW'(cfg_wr.data));
                default:
                begin
                end
            endcase
        end
        slab_prod = (PROD_W'(row_last_next) + PROD_W'(1))
                  * (PROD_W'(col_last_next) + PROD_W'(1));
        slab_next = 32'(slab_prod);
    end

    assign rows_ext  = OFF_W'(row_last_reg) + OFF_W'(1);
    assign col_end   = col_pos_reg >= col_last_reg;
    assign row_end   = row_pos_reg >= row_last_reg;
    assign batch_end = batch_pos_reg >= batch_last_reg;

    assign addr.index = batch_base_reg + 32'(col_offset_reg) + 32'(row_pos_reg);
    assign addr.last  = col_end && row_end && batch_end;

    always_comb
    begin
        col_pos_next    = col_pos_reg;
        row_pos_next    = row_pos_reg;
        batch_pos_next  = batch_pos_reg;
        col_offset_next = col_offset_reg;
        batch_base_next = batch_base_reg;
        if (step)
        begin
            priority if (!col_end)
            begin
                col_pos_next    = col_pos_reg + DIM_BITS'(1);
                col_offset_next = col_offset_reg + rows_ext;
            end
            else
            begin
                col_pos_next    = '0;
                col_offset_next = '0;
                priority if (!row_end)
                    row_pos_next = row_pos_reg + DIM_BITS'(1);
                else
                begin
                    row_pos_next = '0;
                    priority if (!batch_end)
                    begin
                        batch_pos_next  = batch_pos_reg + BATCH_BITS'(1);
                        batch_base_next = batch_base_reg + slab_reg;
                    end
                    else
                    begin
                        batch_pos_next  = '0;
                        batch_base_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg   <= '0;
            row_last_reg   <= '0;
            batch_last_reg <= '0;
            slab_reg       <= 32'd1;
            col_pos_reg    <= '0;
            row_pos_reg    <= '0;
            batch_pos_reg  <= '0;
            col_offset_reg <= '0;
            batch_base_reg <= '0;
        end
        else
        begin
            col_last_reg   <= col_last_next;
            row_last_reg   <= row_last_next;
            batch_last_reg <= batch_last_next;
            slab_reg       <= slab_next;
            col_pos_reg    <= col_pos_next;
            row_pos_reg    <= row_pos_next;
            batch_pos_reg  <= batch_pos_next;
            col_offset_reg <= col_offset_next;
            batch_base_reg <= batch_base_next;
        end
    end

    `BTAG_ASSERT(a_wrap_to_start, clk, rst_n, step && addr.last |=> (col_pos_reg == '0) && (row_pos_reg == '0) && (batch_pos_reg == '0) && (batch_base_reg == '0))
    `BTAG_ASSERT(a_col_offset_step, clk, rst_n, step && !col_end |=> col_offset_reg == $past(col_offset_reg) + $past(rows_ext))
    `BTAG_ASSERT(a_hold_when_idle, clk, rst_n, !step |=> $stable(col_pos_reg) && $stable(row_pos_reg) && $stable(batch_pos_reg) && $stable(batch_base_reg))

endmodule

// ===== hdl/batched_transpose_address_gen.sv =====
// Batched transpose address generator, top level.
// Depends on btag_pkg, btag_if.sv and btag_index_gen.
//
// Takes one tensor element per beat in input order (batch, row, column) and
// returns it with its index in the transposed tensor,
// batch * rows * cols + col * rows + row, plus a flag on the tensor's final
// element. One beat per clock is sustained while the result side is ready;
// each result appears in the cycle after its input beat, out of a single
// output register, and a new beat is taken whenever that register is empty or
// being drained. The index comes from running counters and offsets updated
// with one add per beat; the slab size is multiplied once per configuration
// write. Shape writes apply from the next beat on; counters are not cleared by
// a write and return to zero after the last element of a tensor.
module batched_transpose_address_gen #(
    parameter int DIM_BITS   = 12,
    parameter int BATCH_BITS = 8,
    parameter int ELEM_BITS  = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    btag_cfg_if.sink      cfg,
    btag_elem_if.sink     elem,
    btag_result_if.source result
);

    localparam logic [btag_pkg::ELEM_W-1:0] VALUE_MASK =
        {btag_pkg::ELEM_W{1'b1}} >> (btag_pkg::ELEM_W - ELEM_BITS);

    btag_pkg::cfg_wr_t cfg_wr;
    btag_pkg::addr_t   addr;
    logic              accept;
    logic              out_valid_reg, out_valid_next;

    logic [btag_pkg::ELEM_W-1:0]  out_value_reg;
    logic [btag_pkg::INDEX_W-1:0] out_index_reg;
    logic                         out_last_reg;

    assign cfg.ready    = 1'b1;
    assign cfg_wr.valid = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    assign elem.ready     = !out_valid_reg || result.ready;
    assign accept         = elem.valid && elem.ready;
    assign out_valid_next = accept || (out_valid_reg && !result.ready);

    btag_index_gen #(
        .DIM_BITS   (DIM_BITS),
        .BATCH_BITS (BATCH_BITS)
    ) u_index_gen (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept),
        .cfg_wr (cfg_wr),
        .addr   (addr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_value_reg <= elem.elem_value & VALUE_MASK;
            out_index_reg <= addr.index;
            out_last_reg  <= addr.last;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.out_value      = out_value_reg;
    assign result.out_index      = out_index_reg;
    assign result.last_of_tensor = out_last_reg;

endmodule

// ===== tb/btag_checker.sv =====
// Scoreboard for the batched transpose address generator: watches the config,
// element and result channels, predicts each destination index and compares.
// Depends on btag_pkg and the channel interfaces of btag_if.sv.
module btag_checker (
    input  logic   clk,
    input  logic   rst_n,
    btag_cfg_if    cfg,
    btag_elem_if   elem,
    btag_result_if result,
    output int     fail_count,
    output int     awaited_count,
    output int     placed_count,
    output int     tensor_ends
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM_BITS   = 12;
    localparam int BATCH_BITS = 8;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic [btag_pkg::ELEM_W-1:0]  value;
        logic [btag_pkg::INDEX_W-1:0] index;
        logic                         last;
    } placement_t;

    logic [btag_pkg::BATCH_CNT_W-1:0] batch_count;
    logic [btag_pkg::CFG_DATA_W-1:0]  rows_in;
    logic [btag_pkg::CFG_DATA_W-1:0]  cols_in;
    logic [DIM_BITS-1:0]              col_pos;
    logic [DIM_BITS-1:0]              row_pos;
    logic [BATCH_BITS-1:0]            batch_pos;
    logic [2*DIM_BITS-1:0]            col_offset;
    logic [btag_pkg::INDEX_W-1:0]     batch_base;
    placement_t                       awaited_placements[$];

    function automatic int unsigned clamp_count(input int unsigned v, input int unsigned max);
        if (v == 0)
            return 1;
        if (v > max)
            return max;
        return v;
    endfunction

    // Destination of one element in input order; advances the running counters.
    function automatic placement_t place_element(input logic [btag_pkg::ELEM_W-1:0] value);
        int unsigned rows;
        int unsigned cols;
        int unsigned batches;
        logic        col_end;
        logic        row_end;
        logic        batch_end;
        placement_t  p;
        rows      = clamp_count(rows_in, 1 << DIM_BITS);
        cols      = clamp_count(cols_in, 1 << DIM_BITS);
        batches   = clamp_count(batch_count, 1 << BATCH_BITS);
        col_end   = col_pos >= cols - 1;
        row_end   = row_pos >= rows - 1;
        batch_end = batch_pos >= batches - 1;
        p.value   = value;
        p.index   = batch_base + col_offset + row_pos;
        p.last    = col_end && row_end && batch_end;
        if (!col_end)
        begin
            col_pos    = col_pos + 1'b1;
            col_offset = col_offset + (2*DIM_BITS)'(rows);
        end
        else
        begin
            col_pos    = '0;
            col_offset = '0;
            if (!row_end)
                row_pos = row_pos + 1'b1;
            else
            begin
                row_pos = '0;
                if (!batch_end)
                begin
                    batch_pos  = batch_pos + 1'b1;
                    batch_base = batch_base + rows * cols;
                end
                else
                begin
                    batch_pos  = '0;
                    batch_base = '0;
                end
            end
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [btag_pkg::ELEM_W-1:0] got,
                                   input logic [btag_pkg::ELEM_W-1:0] want);
        if (fail_count < MAX_PRINTS)
            $display("%0t ns btag_checker: %s got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        placement_t want;
        if (!rst_n)
        begin
            batch_count   = 1;
            rows_in       = 1;
            cols_in       = 1;
            col_pos       = '0;
            row_pos       = '0;
            batch_pos     = '0;
            col_offset    = '0;
            batch_base    = '0;
            awaited_placements.delete();
            awaited_count <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                placed_count++;
                if (result.last_of_tensor === 1'b1)
                    tensor_ends++;
                if (awaited_placements.size() == 0)
                    report_mismatch("unexpected result beat, index",
                                    64'(result.out_index), '0);
                else
                begin
                    want = awaited_placements.pop_front();
                    if (result.out_value !== want.value)
                        report_mismatch("out_value", result.out_value, want.value);
                    if (result.out_index !== want.index)
                        report_mismatch("out_index", 64'(result.out_index), 64'(want.index));
                    if (result.last_of_tensor !== want.last)
                        report_mismatch("last_of_tensor", 64'(result.last_of_tensor),
                                        64'(want.last));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    btag_pkg::REG_BATCH_COUNT:
                        batch_count = cfg.data[btag_pkg::BATCH_CNT_W-1:0];
                    btag_pkg::REG_ROWS_IN:     rows_in = cfg.data;
                    btag_pkg::REG_COLS_IN:     cols_in = cfg.data;
                    default: ;
                endcase
            end
            if (elem.valid && elem.ready)
                awaited_placements.push_back(place_element(elem.elem_value));
            awaited_count <= awaited_placements.size();
        end
    end

endmodule

// ===== tb/tb_batched_transpose_address_gen.sv =====
// Top of the batched transpose address generator testbench: clock, reset and
// stimulus on the config and element channels. Depends on btag_pkg, btag_if.sv,
// btag_checker and the block itself.
module tb_batched_transpose_address_gen;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [btag_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int MAX_ROWS     = 4096;
    localparam int MAX_BATCHES  = 256;
    localparam int DRAIN_CYCLES = 4;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 60;
    localparam int RANDOM_ITEMS = 880;

    logic        clk = 1'b0;
    logic        rst_n;
    int          fail_count;
    int          awaited_count;
    int          placed_count;
    int          tensor_ends;
    int          send_idle_pct = 7;
    int          recv_idle_pct = 82;
    int          sent_total = 0;
    int          shape_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          quiet_cycles = 0;

    btag_cfg_if    cfg_ch ();
    btag_elem_if   elem_ch ();
    btag_result_if result_ch ();

    batched_transpose_address_gen u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .elem   (elem_ch),
        .result (result_ch)
    );

    btag_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_ch),
        .elem          (elem_ch),
        .result        (result_ch),
        .fail_count    (fail_count),
        .awaited_count (awaited_count),
        .placed_count  (placed_count),
        .tensor_ends   (tensor_ends)
    );

    always #1 clk = ~clk;

    // Result side: random stalls, plus one long hold-off to back up the input.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end
        else if (!hold_done && sent_total >= HOLD_AT)
        begin
            result_ch.ready <= 1'b0;
            hold_left       <= HOLD_CYCLES;
            hold_done       <= 1'b1;
        end
        else
            result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((elem_ch.valid && elem_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("batched_transpose_address_gen: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_elem(input logic [btag_pkg::ELEM_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            elem_ch.valid <= 1'b0;
            @(posedge clk);
        end
        elem_ch.valid      <= 1'b1;
        elem_ch.elem_value <= value;
        @(posedge clk);
        while (!elem_ch.ready)
            @(posedge clk);
        sent_total++;
    endtask

    task automatic write_reg(input logic [btag_pkg::CFG_IDX_W-1:0] idx,
                             input logic [btag_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Waits until every placement is back, then rewrites the shape.
    task automatic reshape(input logic [btag_pkg::CFG_DATA_W-1:0] batches,
                           input logic [btag_pkg::CFG_DATA_W-1:0] rows,
                           input logic [btag_pkg::CFG_DATA_W-1:0] cols,
                           input bit with_unused);
        elem_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (with_unused)
            write_reg(REG_UNUSED, 13'($urandom));
        if ($urandom_range(0, 1))
        begin
            write_reg(btag_pkg::REG_BATCH_COUNT, batches);
            write_reg(btag_pkg::REG_ROWS_IN, rows);
            write_reg(btag_pkg::REG_COLS_IN, cols);
        end
        else
        begin
            write_reg(btag_pkg::REG_COLS_IN, cols);
            write_reg(btag_pkg::REG_ROWS_IN, rows);
            write_reg(btag_pkg::REG_BATCH_COUNT, batches);
        end
        cfg_ch.valid <= 1'b0;
        shape_count++;
    endtask

    function automatic int unsigned clamped(input int unsigned v, input int unsigned max);
        return (v == 0) ? 1 : ((v > max) ? max : v);
    endfunction

    task automatic random_shape(inout int sent);
        logic [btag_pkg::CFG_DATA_W-1:0] bw;
        logic [btag_pkg::CFG_DATA_W-1:0] rw;
        logic [btag_pkg::CFG_DATA_W-1:0] cw;
        int unsigned                     sel;
        int unsigned                     vol;
        int unsigned                     n;
        logic [btag_pkg::ELEM_W-1:0]     value;
        sel = $urandom_range(0, 19);
        bw  = 13'($urandom_range(1, 3));
        rw  = 13'($urandom_range(1, 6));
        cw  = 13'($urandom_range(1, 6));
        case (sel)
            14: begin bw = '0; rw = '0; end
            15: rw = 13'($urandom_range(MAX_ROWS + 1, 8191));
            16: begin bw = 13'($urandom_range(200, 511)); rw = 13'd1; cw = 13'd1; end
            17: cw = 13'($urandom_range(3000, MAX_ROWS));
            18: bw = bw | 13'($urandom_range(1, 15) << btag_pkg::BATCH_CNT_W);
            default: ;
        endcase
        vol = clamped(bw[btag_pkg::BATCH_CNT_W-1:0], MAX_BATCHES) * clamped(rw, MAX_ROWS)
            * clamped(cw, MAX_ROWS);
        if (vol <= 48 && sel != 19)
            n = vol * $urandom_range(1, 3);
        else
            n = $urandom_range(1, (vol < 40) ? vol : 40);
        reshape(bw, rw, cw, $urandom_range(0, 7) == 0);
        repeat (n)
        begin
            case ($urandom_range(0, 15))
                0:       value = '0;
                1:       value = '1;
                default: value = {$urandom, $urandom};
            endcase
            send_elem(value);
        end
        sent += n;
    endtask

    initial
    begin
        int random_sent;
        random_sent = 0;
        rst_n              <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= btag_pkg::REG_BATCH_COUNT;
        cfg_ch.data        <= '0;
        elem_ch.valid      <= 1'b0;
        elem_ch.elem_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset shape is a single element per tensor
        send_elem('0);
        send_elem('1);
        reshape(2, 3, 2, 1'b0);
        for (int i = 0; i < 12; i++)
            send_elem(64'h0123_4567_89ab_cdef ^ {8{8'(i)}});
        // largest shape, left mid-tensor
        reshape(MAX_BATCHES, MAX_ROWS, MAX_ROWS, 1'b0);
        send_elem(64'h5555_5555_5555_5555);
        send_elem(64'haaaa_aaaa_aaaa_aaaa);
        send_elem({$urandom, $urandom});
        // shrink under the counters, zero counts read as one
        reshape(0, 0, 1, 1'b0);
        send_elem({$urandom, $urandom});
        // counts above range clamp, batch bits above the register drop
        reshape(13'h1fff, 13'h1fff, 13'h1fff, 1'b1);
        send_elem({$urandom, $urandom});
        send_elem({$urandom, $urandom});

        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 82;
            end
            else if (random_sent < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 82;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_shape(random_sent);
        end

        elem_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_count != 0);
        repeat (8) @(posedge clk);
        $display("run covered %0d element beats over %0d shape settings", placed_count,
                 shape_count);
        $display("%0d tensor ends seen, %0d field errors", tensor_ends, fail_count);
        if (fail_count == 0)
            $display("batched_transpose_address_gen: match");
        else
            $display("batched_transpose_address_gen: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/btag_pkg.sv
hdl/btag_if.sv
hdl/btag_index_gen.sv
hdl/batched_transpose_address_gen.sv
tb/btag_checker.sv
tb/tb_batched_transpose_address_gen.sv
